[hw/rtl/kdd_pkg.sv]
`default_nettype none

package kdd_pkg;

    // Default number of list entries.
    localparam int unsigned CAPACITY = 32;

    localparam int unsigned KEY_W = 32;

    typedef enum logic [2:0] {
        ACT_INSERT     = 3'd0,
        ACT_DEL_KEY    = 3'd1,
        ACT_DEL_FIRST  = 3'd2,
        ACT_DEL_LAST   = 3'd3,
        ACT_DUMP       = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEL,
        ST_DUMP
    } t_state;

    // What every cell does in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_PULL,
        CELL_ROT
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic signed [KEY_W-1:0]  key;
    } t_cell_ctrl;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [KEY_W-1:0]  key_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [KEY_W-1:0]  entry_value;
        logic                     has_entry;
        logic                     last;
    } t_out_word;

endpackage

`default_nettype wire

[hw/rtl/kdd_cell.sv]
`default_nettype none

// One list position. Takes its neighbor's value on a shift, and registers
// whether it holds the key being searched for.
module kdd_cell (
    input  wire logic                              i_clk,
    input  wire kdd_pkg::t_cell_ctrl               i_ctrl,
    input  wire logic                              i_occ,
    input  wire logic                              i_sel,
    input  wire logic                              i_tail,
    input  wire logic signed [kdd_pkg::KEY_W-1:0]  i_prev,
    input  wire logic signed [kdd_pkg::KEY_W-1:0]  i_next,
    input  wire logic signed [kdd_pkg::KEY_W-1:0]  i_front,
    output logic signed [kdd_pkg::KEY_W-1:0]       o_value,
    output logic                                   o_match
);

    logic signed [kdd_pkg::KEY_W-1:0] r_value;
    logic signed [kdd_pkg::KEY_W-1:0] n_value;
    logic                             r_match;

    always_comb begin
        unique case (i_ctrl.op)
            kdd_pkg::CELL_HOLD: n_value = r_value;
            kdd_pkg::CELL_PUSH: n_value = i_prev;
            kdd_pkg::CELL_PULL: n_value = i_sel ? i_next : r_value;
            kdd_pkg::CELL_ROT:  n_value = i_tail ? i_front : i_next;
            default:            n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_match <= i_occ && (r_value == i_ctrl.key);
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

`default_nettype wire

[hw/rtl/keyed_deque_with_delete.sv]
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit keys, front first. A command
// word (action and key) is taken at a clock edge where start is high and
// busy is low. Insert at the front, delete the front entry and delete the
// back entry finish at the accepting edge: busy stays low and a new word may
// follow in the very next cycle. Delete by key first has every cell compare
// its entry with the key, then shifts the first match and all behind it one
// place toward the front, so busy is high for one cycle. Dump sends out one
// entry per cycle, busy high until the last: the chain rotates toward the
// front and the front cell is sent out each cycle, which leaves the list as
// it was once every entry has gone out. Each result word appears on
// o_result for exactly one cycle, flagged by o_strobe and registered at the
// edge that produced it; the receiver cannot stall the block and must take
// every word as it comes. Unused action codes are accepted and ignored.
// Reset clears the state, the counts and the strobe; stored keys are
// undefined until written, and no entry beyond the count is ever reported.
module keyed_deque_with_delete #(
    parameter int unsigned CAPACITY = kdd_pkg::CAPACITY
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire kdd_pkg::t_in_word  i_item,
    output logic                    busy,
    output logic                    o_strobe,
    output kdd_pkg::t_out_word      o_result
);

    // Count width holds CAPACITY itself.
    localparam int unsigned CW  = $clog2(CAPACITY + 1);
    // Levels of the prefix OR over the match flags.
    localparam int unsigned LVL = $clog2(CAPACITY);

    kdd_pkg::t_state     r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_left,  n_left;
    logic                r_strobe, n_strobe;
    kdd_pkg::t_out_word  r_result, n_result;
    kdd_pkg::t_cell_ctrl w_ctrl;

    logic signed [kdd_pkg::KEY_W-1:0] w_value [CAPACITY];
    logic [CAPACITY-1:0]              w_match;
    logic [CAPACITY-1:0]              w_prefix;
    logic [CAPACITY-1:0]              w_sel;
    logic [CAPACITY-1:0]              w_occ;
    logic [CAPACITY-1:0]              w_tail;
    logic                             w_found;

    // The chain of cells. Cell 0 is the front of the list; it receives the
    // key on an insert, and the front value is fed back to the tail on a
    // rotation step of a dump.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [CW-1:0] IDX  = CW'(g);
        localparam logic [CW-1:0] IDX1 = CW'(g + 1);

        logic signed [kdd_pkg::KEY_W-1:0] w_prev;
        logic signed [kdd_pkg::KEY_W-1:0] w_next;

        assign w_occ[g]  = IDX < r_count;
        assign w_tail[g] = IDX1 == r_count;

        if (g == 0) begin : g_first
            assign w_prev = w_ctrl.key;
        end else begin : g_mid
            assign w_prev = w_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign w_next = w_value[g];
        end else begin : g_inner
            assign w_next = w_value[g+1];
        end

        kdd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_occ   (w_occ[g]),
            .i_sel   (w_sel[g]),
            .i_tail  (w_tail[g]),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_front (w_value[0]),
            .o_value (w_value[g]),
            .o_match (w_match[g])
        );
    end

    // A cell at or behind the first match pulls from its neighbor. The
    // prefix OR is built in log2(CAPACITY) levels.
    always_comb begin
        logic [CAPACITY-1:0] p;
        p = w_match;
        for (int lv = 0; lv < LVL; lv++) begin
            p = p | (p << (1 << lv));
        end
        w_prefix = p;
    end

    assign w_found = |w_match;
    assign w_sel   = (r_state == kdd_pkg::ST_DEL) ? w_prefix : {CAPACITY{1'b1}};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_strobe    = 1'b0;
        n_result    = '0;
        w_ctrl.op   = kdd_pkg::CELL_HOLD;
        w_ctrl.key  = i_item.key_value;

        unique case (r_state)
            kdd_pkg::ST_IDLE: begin
                if (start) begin
                    unique case (kdd_pkg::t_action'(i_item.action))
                        kdd_pkg::ACT_INSERT: begin
                            n_strobe        = 1'b1;
                            n_result.last   = 1'b1;
                            if (r_count == CW'(CAPACITY)) begin
                                n_result.status = kdd_pkg::STAT_FULL;
                            end else begin
                                w_ctrl.op       = kdd_pkg::CELL_PUSH;
                                n_count         = r_count + 1'b1;
                                n_result.status = kdd_pkg::STAT_OK;
                            end
                        end
                        kdd_pkg::ACT_DEL_KEY: begin
                            // Cells register their compare at this edge.
                            n_state = kdd_pkg::ST_DEL;
                        end
                        kdd_pkg::ACT_DEL_FIRST: begin
                            n_strobe      = 1'b1;
                            n_result.last = 1'b1;
                            if (r_count == '0) begin
                                n_result.status = kdd_pkg::STAT_EMPTY;
                            end else begin
                                w_ctrl.op       = kdd_pkg::CELL_PULL;
                                n_count         = r_count - 1'b1;
                                n_result.status = kdd_pkg::STAT_OK;
                            end
                        end
                        kdd_pkg::ACT_DEL_LAST: begin
                            n_strobe      = 1'b1;
                            n_result.last = 1'b1;
                            if (r_count == '0) begin
                                n_result.status = kdd_pkg::STAT_EMPTY;
                            end else begin
                                n_count         = r_count - 1'b1;
                                n_result.status = kdd_pkg::STAT_OK;
                            end
                        end
                        kdd_pkg::ACT_DUMP: begin
                            if (r_count == '0) begin
                                // Empty list: one word with no entry.
                                n_strobe        = 1'b1;
                                n_result.last   = 1'b1;
                                n_result.status = kdd_pkg::STAT_OK;
                            end else begin
                                n_left  = r_count;
                                n_state = kdd_pkg::ST_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            kdd_pkg::ST_DEL: begin
                n_strobe      = 1'b1;
                n_result.last = 1'b1;
                n_state       = kdd_pkg::ST_IDLE;
                if (w_found) begin
                    w_ctrl.op       = kdd_pkg::CELL_PULL;
                    n_count         = r_count - 1'b1;
                    n_result.status = kdd_pkg::STAT_OK;
                end else begin
                    n_result.status = kdd_pkg::STAT_NOT_FOUND;
                end
            end
            kdd_pkg::ST_DUMP: begin
                n_strobe             = 1'b1;
                n_result.status      = kdd_pkg::STAT_OK;
                n_result.entry_value = w_value[0];
                n_result.has_entry   = 1'b1;
                n_result.last        = (r_left == CW'(1));
                w_ctrl.op            = kdd_pkg::CELL_ROT;
                n_left               = r_left - 1'b1;
                if (r_left == CW'(1)) begin
                    n_state = kdd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kdd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kdd_pkg::ST_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign busy     = (r_state != kdd_pkg::ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

[hw/rtl/kdd_checker.sv]
`default_nettype none

module kdd_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire kdd_pkg::t_in_word  i_item,
    input wire logic               busy,
    input wire logic               o_strobe,
    input wire kdd_pkg::t_out_word o_result
);

    // A word without an entry is always the only word of its command.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.has_entry |-> o_result.last && o_result.entry_value == '0)
        else $error("word without entry must be final and zero");

    // Dumped entries always carry status ok.
    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.has_entry |-> o_result.status == kdd_pkg::STAT_OK)
        else $error("dumped entry with bad status");

    // An insert answers in the next cycle with a single word.
    a_insert_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.action == kdd_pkg::ACT_INSERT
        |=> o_strobe && o_result.last && !o_result.has_entry)
        else $error("insert gave no status word");

    // A delete by key keeps the block busy for its compare cycle.
    a_delkey_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.action == kdd_pkg::ACT_DEL_KEY |=> busy ##1 o_strobe)
        else $error("delete by key timing broken");

    // Reset leaves the block idle and quiet.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("not idle after reset");

endmodule

bind keyed_deque_with_delete kdd_checker u_kdd_checker (.*);

`default_nettype wire
